### rtl/fan_power_curve_control_core_defines.svh
// Assertion macros shared by the fan power curve control RTL.
`ifndef FAN_POWER_CURVE_CONTROL_CORE_DEFINES_SVH
`define FAN_POWER_CURVE_CONTROL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define FPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FPC_ASSERT_IMPL(lbl, ante, cons, msg)
`define FPC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/fpc_pkg.sv
// Shared types and constants of the fan power curve control block.
package fpc_pkg;

	// Configuration register indexes.
	localparam logic [2:0] REG_MIN_POWER  = 3'd0;
	localparam logic [2:0] REG_MIN_TEMP   = 3'd1;
	localparam logic [2:0] REG_MAX_TEMP   = 3'd2;
	localparam logic [2:0] REG_CAN_STOP   = 3'd3;
	localparam logic [2:0] REG_FAN_A_KIND = 3'd4;
	localparam logic [2:0] REG_FAN_B_KIND = 3'd5;

	// Fan kind codes.
	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_PWM  = 3'd5;

	// Register reset values.
	localparam logic [6:0] RST_MIN_POWER  = 7'd25;
	localparam logic [7:0] RST_MIN_TEMP   = 8'd30;
	localparam logic [7:0] RST_MAX_TEMP   = 8'd50;
	localparam logic [2:0] RST_FAN_A_KIND = 3'd1;
	localparam logic [2:0] RST_FAN_B_KIND = 3'd0;

	// Power levels.
	localparam logic [6:0] PCT_FULL        = 7'd100;
	localparam logic [6:0] BOOST_POWER     = 7'd85;
	localparam logic [6:0] FULL_POWER_MARK = 7'd98;
	localparam logic [6:0] PWM_FULL        = 7'd120;
	localparam logic [1:0] HYST_DEGREES    = 2'd2;

	// p / 5 for p up to 100 as (p * 205) >> 10.
	localparam logic [7:0] FIFTH_RECIP = 8'd205;
	localparam int         FIFTH_SHIFT = 10;

	// Serial multiply and divide unit widths.
	localparam int OPW   = 8;
	localparam int PRODW = 2 * OPW;

	typedef struct packed {
		logic [6:0] min_power;
		logic [7:0] min_temp;
		logic [7:0] max_temp;
		logic       can_stop;
		logic [2:0] fan_a_kind;
		logic [2:0] fan_b_kind;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [OPW-1:0]   a;
		logic [OPW-1:0]   b;
		logic [OPW-1:0]   d;
	} md_req_t;

	typedef struct packed {
		logic             done;
		logic [PRODW-1:0] quot;
	} md_rsp_t;

endpackage

### rtl/fpc_cfg_regs.sv
// Configuration register file of the fan power curve control block.
module fpc_cfg_regs
	import fpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_power  <= RST_MIN_POWER;
			cfg_q.min_temp   <= RST_MIN_TEMP;
			cfg_q.max_temp   <= RST_MAX_TEMP;
			cfg_q.can_stop   <= 1'b0;
			cfg_q.fan_a_kind <= RST_FAN_A_KIND;
			cfg_q.fan_b_kind <= RST_FAN_B_KIND;
		end else if (cfg_valid) begin
			// Indexes beyond the register list are accepted and dropped.
			case (cfg_index)
				REG_MIN_POWER:  cfg_q.min_power  <= cfg_data[6:0];
				REG_MIN_TEMP:   cfg_q.min_temp   <= cfg_data;
				REG_MAX_TEMP:   cfg_q.max_temp   <= cfg_data;
				REG_CAN_STOP:   cfg_q.can_stop   <= cfg_data[0];
				REG_FAN_A_KIND: cfg_q.fan_a_kind <= cfg_data[2:0];
				REG_FAN_B_KIND: cfg_q.fan_b_kind <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

endmodule

### rtl/fpc_muldiv.sv
// Bit-serial unsigned multiply followed by restoring divide: (a * b) / d.
module fpc_muldiv
	import fpc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	`include "fan_power_curve_control_core_defines.svh"

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_MUL  = 2'd1;
	localparam logic [1:0] PH_DIV  = 2'd2;

	localparam logic [3:0] MUL_LAST = 4'(OPW - 1);
	localparam logic [3:0] DIV_LAST = 4'(PRODW - 1);

	logic [1:0]       phase_q;
	logic [3:0]       cnt_q;
	logic             done_q;
	logic [PRODW-1:0] acc_q;
	logic [PRODW-1:0] mcand_q;
	logic [OPW-1:0]   mplier_q;
	logic [OPW-1:0]   d_q;
	logic [OPW-1:0]   rem_q;

	logic [OPW:0]     trial;
	logic             fits;

	// The dividend shifts out of acc_q from the top while quotient bits enter below.
	assign trial = {rem_q, acc_q[PRODW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_MUL;
						cnt_q   <= '0;
					end
				end
				PH_MUL: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == MUL_LAST) begin
						phase_q <= PH_DIV;
						cnt_q   <= '0;
					end
				end
				PH_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					acc_q    <= '0;
					mcand_q  <= {{(PRODW-OPW){1'b0}}, req.a};
					mplier_q <= req.b;
					d_q      <= req.d;
				end
			end
			PH_MUL: begin
				if (mplier_q[0]) begin
					acc_q <= acc_q + mcand_q;
				end
				mcand_q  <= {mcand_q[PRODW-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[OPW-1:1]};
				if (cnt_q == MUL_LAST) begin
					rem_q <= '0;
				end
			end
			PH_DIV: begin
				if (fits) begin
					rem_q <= OPW'(trial - {1'b0, d_q});
				end else begin
					rem_q <= trial[OPW-1:0];
				end
				acc_q <= {acc_q[PRODW-2:0], fits};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = acc_q;

	`FPC_ASSERT_IMPL(a_start_when_idle, req.start, phase_q == PH_IDLE, "muldiv started while busy")
	`FPC_ASSERT_NEXT(a_done_single, done_q, !done_q, "muldiv done held for two cycles")
	`FPC_ASSERT_IMPL(a_rem_below_divisor, phase_q == PH_DIV, rem_q < d_q, "remainder not below divisor")

endmodule

### rtl/fan_power_curve_control_core.sv
// Top level of the fan power curve control block for one fan channel.
//
// One input transfer carries a temperature and a one-second tick; one result transfer
// follows with the power percentage, the buck pulse width and the PWM compare value. Both
// the ramp quotient and the pulse width go through one shared bit-serial multiply and
// restoring divide unit, a multiply phase and then a divide phase a pass; an item below
// the minimum temperature or with equal ramp limits skips the ramp pass. Items are handled
// one at a time; the result register lets the next item enter while a result is still
// waiting.
// Configuration writes are taken every cycle and must only be made while the block is idle.
module fan_power_curve_control_core
	import fpc_pkg::*;
#(
	parameter int PULSE_STEPS   = 45,
	parameter int ONE_FAN_STEPS = 36,
	parameter int BOOST_TIME    = 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic signed [7:0] temperature,
	input  logic              second_tick,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [6:0]        power_pct,
	output logic [5:0]        pulse_width,
	output logic [6:0]        pwm_duty,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data
);

	`include "fan_power_curve_control_core_defines.svh"

	localparam logic [7:0] PULSE_W    = 8'(PULSE_STEPS);
	localparam logic [7:0] ONE_FAN_W  = 8'(ONE_FAN_STEPS);
	localparam logic [1:0] BOOST_INIT = 2'(BOOST_TIME);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVAL  = 3'd1;
	localparam logic [2:0] ST_CURVE = 3'd2;
	localparam logic [2:0] ST_BOOST = 3'd3;
	localparam logic [2:0] ST_PULSE = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	cfg_t    cfg;
	md_req_t md_req;
	md_rsp_t md_rsp;

	logic [2:0]        state_q;
	logic signed [8:0] t_q;
	logic              tick_q;
	logic              prev_zero_q;
	logic              stop_q;
	logic              neg_q;
	logic [6:0]        p0_q;
	logic [6:0]        p_q;
	logic [1:0]        boost_q;
	logic [6:0]        last_power_q;
	logic              out_valid_q;
	logic [6:0]        power_q;
	logic [5:0]        pw_q;
	logic [6:0]        duty_q;

	logic              accept;
	logic              out_free;
	logic signed [8:0] lo9;
	logic signed [8:0] hi9;
	logic              below;
	logic              flat;
	logic signed [9:0] diff_t;
	logic              mp_over;
	logic [6:0]        mp_sat;
	logic [6:0]        slope_mag;
	logic              span_neg;
	logic [8:0]        span;
	logic signed [17:0] quot_s;
	logic signed [17:0] curve_sum;
	logic [6:0]        curve_p;
	logic              no_fan;
	logic              two_fans;
	logic              pwm_fan;
	logic [1:0]        boost_arm;
	logic [6:0]        boost_p;
	logic [14:0]       fifth_prod;
	logic [5:0]        pw_next;
	logic [6:0]        duty_next;

	fpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fpc_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	// Curve decision.
	assign lo9       = $signed({cfg.min_temp[7], cfg.min_temp});
	assign hi9       = $signed({cfg.max_temp[7], cfg.max_temp});
	assign below     = t_q < lo9;
	assign flat      = cfg.min_temp == cfg.max_temp;
	assign diff_t    = $signed({t_q[8], t_q}) - $signed({lo9[8], lo9});
	assign mp_over   = cfg.min_power > PCT_FULL;
	assign mp_sat    = mp_over ? PCT_FULL : cfg.min_power;
	assign slope_mag = mp_over ? cfg.min_power - PCT_FULL : PCT_FULL - cfg.min_power;
	assign span_neg  = hi9 < lo9;
	assign span      = span_neg ? 9'(lo9 - hi9) : 9'(hi9 - lo9);

	// The divider works on magnitudes, so the truncating quotient only needs its sign back.
	always_comb begin
		quot_s    = $signed({2'b00, md_rsp.quot});
		if (neg_q) begin
			quot_s = -quot_s;
		end
		curve_sum = quot_s + $signed({11'd0, cfg.min_power});
		if (curve_sum < 0) begin
			curve_p = '0;
		end else if (curve_sum > $signed({11'd0, PCT_FULL})) begin
			curve_p = PCT_FULL;
		end else begin
			curve_p = curve_sum[6:0];
		end
	end

	// Startup boost and fitted fans.
	assign no_fan   = (cfg.fan_a_kind == KIND_NONE) && (cfg.fan_b_kind == KIND_NONE);
	assign two_fans = (cfg.fan_a_kind != KIND_NONE) && (cfg.fan_b_kind != KIND_NONE);
	assign pwm_fan  = (cfg.fan_a_kind == KIND_PWM) || (cfg.fan_b_kind == KIND_PWM);

	always_comb begin
		boost_arm = stop_q ? 2'd0 : boost_q;
		if (prev_zero_q && (p0_q != 7'd0)) begin
			boost_arm = BOOST_INIT;
		end
		boost_p = (boost_arm != 2'd0) ? BOOST_POWER : p0_q;
		if (no_fan) begin
			boost_p = '0;
		end
	end

	always_comb begin
		md_req = '0;
		case (state_q)
			ST_EVAL: begin
				md_req.start = !below && !flat;
				md_req.a     = diff_t[7:0];
				md_req.b     = {1'b0, slope_mag};
				md_req.d     = span[7:0];
			end
			ST_BOOST: begin
				md_req.start = 1'b1;
				md_req.a     = {1'b0, boost_p};
				md_req.b     = two_fans ? PULSE_W : ONE_FAN_W;
				md_req.d     = {1'b0, PCT_FULL};
			end
			default: ;
		endcase
	end

	// Output values.
	assign fifth_prod = {8'd0, p_q} * {7'd0, FIFTH_RECIP};
	assign pw_next    = (pwm_fan || (p_q >= FULL_POWER_MARK)) ? PULSE_W[5:0] : md_rsp.quot[5:0];
	assign duty_next  = pwm_fan ? p_q + {2'b00, fifth_prod[FIFTH_SHIFT+4:FIFTH_SHIFT]} : PWM_FULL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			boost_q      <= BOOST_INIT;
			last_power_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= (below || flat) ? ST_BOOST : ST_CURVE;
				end
				ST_CURVE: begin
					if (md_rsp.done) begin
						state_q <= ST_BOOST;
					end
				end
				ST_BOOST: begin
					boost_q <= boost_arm;
					state_q <= ST_PULSE;
				end
				ST_PULSE: begin
					if (md_rsp.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						last_power_q <= p_q;
						if (tick_q && (boost_q != 2'd0)) begin
							boost_q <= boost_q - 2'd1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			// While the fan is off the temperature is read two degrees low.
			t_q         <= $signed({temperature[7], temperature}) -
				((last_power_q == 7'd0) ? $signed({7'd0, HYST_DEGREES}) : 9'sd0);
			tick_q      <= second_tick;
			prev_zero_q <= last_power_q == 7'd0;
		end
		if (state_q == ST_EVAL) begin
			stop_q <= below && cfg.can_stop;
			neg_q  <= mp_over ^ span_neg;
			if (below) begin
				p0_q <= cfg.can_stop ? 7'd0 : mp_sat;
			end else begin
				p0_q <= PCT_FULL;
			end
		end
		if ((state_q == ST_CURVE) && md_rsp.done) begin
			p0_q <= curve_p;
		end
		if (state_q == ST_BOOST) begin
			p_q <= boost_p;
		end
		if ((state_q == ST_DONE) && out_free) begin
			power_q <= p_q;
			pw_q    <= pw_next;
			duty_q  <= duty_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign power_pct   = power_q;
	assign pulse_width = pw_q;
	assign pwm_duty    = duty_q;

	`FPC_ASSERT_IMPL(a_boost_range, 1'b1, boost_q <= BOOST_INIT, "boost countdown out of range")
	`FPC_ASSERT_IMPL(a_power_range, out_valid_q, power_q <= PCT_FULL, "power above full scale")

endmodule

### bench/tb_fan_power_curve_control_core.sv
// Self-checking testbench for the fan power curve control core of one fan channel.
`timescale 1ns / 100ps

module tb_fan_power_curve_control_core;
	import fpc_pkg::*;

	localparam int PULSE_STEPS   = 45;
	localparam int ONE_FAN_STEPS = 36;
	localparam int BOOST_TIME    = 3;
	localparam int RANDOM_READINGS = 1250;
	localparam int LONG_HOLD     = 400;
	localparam int HOLD_AFTER    = 300;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 60;

	typedef struct {
		logic [6:0] power_pct;
		logic [5:0] pulse_width;
		logic [6:0] pwm_duty;
	} fan_drive_t;

	// Mirrors the channel's settings and state and keeps the drive values still owed.
	class power_curve_scoreboard;
		cfg_t       settings;
		logic [6:0] prev_power;
		logic [1:0] boost_left;
		fan_drive_t pending_drive[$];
		int         n_readings;
		int         n_drives;
		int         n_errors;

		function new();
			settings.min_power  = RST_MIN_POWER;
			settings.min_temp   = RST_MIN_TEMP;
			settings.max_temp   = RST_MAX_TEMP;
			settings.can_stop   = 1'b0;
			settings.fan_a_kind = RST_FAN_A_KIND;
			settings.fan_b_kind = RST_FAN_B_KIND;
			prev_power = '0;
			boost_left = 2'(BOOST_TIME);
		endfunction

		function void write_setting(logic [2:0] index, logic [7:0] data);
			case (index)
				REG_MIN_POWER:  settings.min_power  = data[6:0];
				REG_MIN_TEMP:   settings.min_temp   = data;
				REG_MAX_TEMP:   settings.max_temp   = data;
				REG_CAN_STOP:   settings.can_stop   = data[0];
				REG_FAN_A_KIND: settings.fan_a_kind = data[2:0];
				REG_FAN_B_KIND: settings.fan_b_kind = data[2:0];
				default: ;
			endcase
		endfunction

		function int clamp_pct(int v);
			if (v < 0)
				return 0;
			if (v > int'(PCT_FULL))
				return int'(PCT_FULL);
			return v;
		endfunction

		// Works out the drive values for one reading and advances the channel state.
		function void note_reading(logic signed [7:0] temp, logic tick);
			fan_drive_t d;
			int t, lo, hi, mp, p, pw;
			bit was_off, pwm_fan, two_fans;
			t  = int'(temp);
			lo = int'($signed(settings.min_temp));
			hi = int'($signed(settings.max_temp));
			mp = int'(settings.min_power);
			was_off  = (prev_power == 0);
			pwm_fan  = (settings.fan_a_kind == KIND_PWM) || (settings.fan_b_kind == KIND_PWM);
			two_fans = (settings.fan_a_kind != KIND_NONE) && (settings.fan_b_kind != KIND_NONE);

			// Hysteresis only applies while the fan is standing still.
			if (was_off)
				t = t - int'(HYST_DEGREES);
			if (t < lo) begin
				if (settings.can_stop) begin
					p = 0;
					boost_left = '0;
				end else begin
					p = clamp_pct(mp);
				end
			end else if (hi == lo) begin
				p = int'(PCT_FULL);
			end else begin
				p = clamp_pct((t - lo) * (int'(PCT_FULL) - mp) / (hi - lo) + mp);
			end

			if (was_off && p > 0)
				boost_left = 2'(BOOST_TIME);
			if (boost_left != 0)
				p = int'(BOOST_POWER);
			if (settings.fan_a_kind == KIND_NONE && settings.fan_b_kind == KIND_NONE)
				p = 0;

			pw = (two_fans ? PULSE_STEPS : ONE_FAN_STEPS) * p / 100;
			if (p >= int'(FULL_POWER_MARK) || pwm_fan)
				pw = PULSE_STEPS;

			d.power_pct   = 7'(p);
			d.pulse_width = 6'(pw);
			d.pwm_duty    = pwm_fan ? 7'(p + p / 5) : PWM_FULL;
			pending_drive.push_back(d);

			prev_power = 7'(p);
			if (tick && boost_left != 0)
				boost_left = boost_left - 2'd1;
			n_readings++;
		endfunction

		function void check_drive(logic [6:0] pct, logic [5:0] pw, logic [6:0] duty);
			fan_drive_t want;
			if (pending_drive.size() == 0) begin
				$error("drive result arrived with no reading outstanding");
				n_errors++;
				return;
			end
			want = pending_drive.pop_front();
			n_drives++;
			if (pct !== want.power_pct) begin
				$error("power_pct: expected %0d, got %0d", want.power_pct, pct);
				n_errors++;
			end
			if (pw !== want.pulse_width) begin
				$error("pulse_width: expected %0d, got %0d", want.pulse_width, pw);
				n_errors++;
			end
			if (duty !== want.pwm_duty) begin
				$error("pwm_duty: expected %0d, got %0d", want.pwm_duty, duty);
				n_errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic signed [7:0] temperature;
	logic              second_tick;
	logic              out_valid;
	logic              out_ready;
	logic [6:0]        power_pct;
	logic [5:0]        pulse_width;
	logic [6:0]        pwm_duty;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [7:0]        cfg_data;

	power_curve_scoreboard sb = new();
	bit no_gaps;
	bit held_once;
	int n_settings;
	int quiet_cycles;

	fan_power_curve_control_core #(
		.PULSE_STEPS  (PULSE_STEPS),
		.ONE_FAN_STEPS(ONE_FAN_STEPS),
		.BOOST_TIME   (BOOST_TIME)
	) u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.temperature(temperature),
		.second_tick(second_tick),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.power_pct  (power_pct),
		.pulse_width(pulse_width),
		.pwm_duty   (pwm_duty),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 11);
	endfunction

	function automatic int clamp_temp(int v);
		if (v < -128)
			return -128;
		if (v > 127)
			return 127;
		return v;
	endfunction

	// Offers one reading after a random gap and holds it until the transfer.
	task automatic send_reading(input int temp, input bit tick);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		temperature <= 8'(temp);
		second_tick <= tick;
		do @(posedge clk); while (!in_ready);
		sb.note_reading(8'(temp), tick);
	endtask

	// Writes all six registers back to back; only called with the channel idle.
	task automatic write_settings(input cfg_t c);
		logic [7:0] data;
		for (int i = 0; i < 6; i++) begin
			case (3'(i))
				REG_MIN_POWER:  data = {1'b0, c.min_power};
				REG_MIN_TEMP:   data = c.min_temp;
				REG_MAX_TEMP:   data = c.max_temp;
				REG_CAN_STOP:   data = {7'd0, c.can_stop};
				REG_FAN_A_KIND: data = {5'd0, c.fan_a_kind};
				default:        data = {5'd0, c.fan_b_kind};
			endcase
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data  <= data;
			do @(posedge clk); while (!cfg_ready);
			sb.write_setting(3'(i), data);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic finish_phase();
		in_valid <= 1'b0;
		while (sb.pending_drive.size() != 0)
			@(posedge clk);
	endtask

	function automatic cfg_t make_settings(int mp, int lo, int hi, bit stop, int ka, int kb);
		cfg_t c;
		c.min_power  = 7'(mp);
		c.min_temp   = 8'(lo);
		c.max_temp   = 8'(hi);
		c.can_stop   = stop;
		c.fan_a_kind = 3'(ka);
		c.fan_b_kind = 3'(kb);
		return c;
	endfunction

	// Settings biased towards the ends of the power and temperature registers' ranges.
	task automatic run_random_phase();
		cfg_t c;
		int mp, lo, hi, a, b, n, t;
		case ($urandom_range(0, 7))
			0: mp = 0;
			1: mp = 127;
			2: mp = 100;
			default: mp = $urandom_range(0, 100);
		endcase
		case ($urandom_range(0, 5))
			0: lo = -128;
			1: lo = 127;
			default: lo = int'($urandom_range(0, 120)) - 40;
		endcase
		case ($urandom_range(0, 5))
			0: hi = lo;
			1: hi = clamp_temp(lo - int'($urandom_range(1, 60)));
			default: hi = clamp_temp(lo + int'($urandom_range(1, 60)));
		endcase
		c = make_settings(mp, lo, hi, 1'($urandom_range(0, 1)), $urandom_range(0, 7),
			$urandom_range(0, 7));
		write_settings(c);
		no_gaps = ($urandom_range(0, 3) == 0);

		// Most readings wander around the ramp so the curve, hysteresis and boost
		// all get exercised; the rest are anywhere in the temperature range.
		a = (lo < hi) ? lo : hi;
		b = (lo < hi) ? hi : lo;
		n = $urandom_range(40, 80);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7)
				t = clamp_temp(a - 8 + int'($urandom_range(0, b - a + 16)));
			else
				t = int'($urandom_range(0, 255)) - 128;
			send_reading(t, $urandom_range(0, 2) == 0);
		end
		finish_phase();
	endtask

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		temperature <= '0;
		second_tick <= 1'b0;
		cfg_valid   <= 1'b0;
		cfg_index   <= REG_MIN_POWER;
		cfg_data    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: boost from standstill, its countdown, the ramp and a faulty sensor.
		send_reading(35, 1'b0);
		send_reading(35, 1'b1);
		send_reading(35, 1'b1);
		send_reading(35, 1'b1);
		send_reading(50, 1'b0);
		send_reading(127, 1'b0);
		send_reading(-128, 1'b1);
		send_reading(29, 1'b0);
		finish_phase();

		// Minimum power above full scale, widest ramp, two PWM fans, stopping allowed.
		write_settings(make_settings(127, -128, 127, 1'b1, int'(KIND_PWM), int'(KIND_PWM)));
		send_reading(127, 1'b1);
		send_reading(-128, 1'b1);
		send_reading(0, 1'b0);
		finish_phase();

		// No fan fitted, with the ramp limits the wrong way round.
		write_settings(make_settings(0, 127, -128, 1'b1, int'(KIND_NONE), int'(KIND_NONE)));
		send_reading(127, 1'b0);
		send_reading(0, 1'b1);
		send_reading(-128, 1'b1);
		finish_phase();

		// Equal ramp limits and the two unused kind codes.
		write_settings(make_settings(100, 20, 20, 1'b0, 6, 7));
		send_reading(20, 1'b1);
		send_reading(19, 1'b0);
		send_reading(21, 1'b1);
		send_reading(-5, 1'b0);
		finish_phase();

		// A tacho fan beside a PWM fan; a stop, then a restart from standstill with a new boost.
		write_settings(make_settings(10, -20, 60, 1'b1, 2, int'(KIND_PWM)));
		send_reading(60, 1'b1);
		send_reading(-30, 1'b1);
		send_reading(0, 1'b1);
		send_reading(-18, 1'b1);
		send_reading(30, 1'b0);
		finish_phase();

		while (sb.n_readings < RANDOM_READINGS + 23)
			run_random_phase();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d readings against %0d drive results across %0d register settings,",
			sb.n_readings, sb.n_drives, n_settings);
		$display("including one long back-pressure stretch on the result side.");
		if (sb.n_errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Result side: random readiness per transfer and one long hold to fill the block.
	initial begin
		int stall;
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!held_once && sb.n_drives >= HOLD_AFTER) begin
				stall     = LONG_HOLD;
				held_once = 1'b1;
			end else begin
				stall = draw_gap();
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_drive(power_pct, pulse_width, pwm_duty);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

endmodule
